// File: design/bhtt_pkg.sv
// ----------------------------------------------------------------------------
// bhtt_pkg
// Shared types, codes and constants of the button hold time tracker.
// ----------------------------------------------------------------------------
package bhtt_pkg;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int KEY_W   = 10;
  localparam int SLOT_W  = 11;
  localparam int STAMP_W = 32;
  localparam int FRAME_W = 10;
  localparam int CFG_W   = 10;
  localparam int FRAC_W  = 17;

  // Holder slots of one logical button
  localparam int KEY_SLOTS = 2;

  // Quotient bits of the fraction divide and the step counter width
  localparam int QBITS = 16;
  localparam int CNT_W = $clog2(QBITS);

  // Register bus
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [SLOT_W-1:0]  NO_KEY_MARK = '1;
  localparam logic [SLOT_W-1:0]  SLOT_FREE   = '0;
  localparam logic [FRAC_W-1:0]  ONE_Q16     = FRAC_W'(1) << QBITS;
  localparam logic [STAMP_W-1:0] TOTAL_MAX   = '1;

  // Register reset values
  localparam logic [CFG_W-1:0] BACKOFF_RST = CFG_W'(100);
  localparam logic [CFG_W-1:0] CREDIT_RST  = CFG_W'(10);

  // Event codes
  typedef enum logic [ACT_W-1:0] {
    ACT_DOWN  = 2'd0,
    ACT_UP    = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  // Register index (byte address bit 2)
  typedef enum logic {
    REG_BACKOFF = 1'b0,
    REG_CREDIT  = 1'b1
  } reg_idx_t;

  // Controller states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_ACC  = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic acc;
    logic prep;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

// File: design/button_hold_time_tracker.sv
// ----------------------------------------------------------------------------
// button_hold_time_tracker
// One logical button held by up to two physical keys, with hold-time query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one event per transfer: key down, key up, clear
//   frame or query fraction. The block takes one event at a time; in_stall
//   is high from the transfer until the event's result is loaded.
//   Result channel (out_*): exactly one result per event: held fraction of
//   the frame (Q1.16, 65536 is one, zero except for queries), held, down
//   impulse and the refused-third-key flag.
//   Down, up and clear events pass through update and accumulate; a query
//   that clamps or has zero frame length also passes through divide setup,
//   and a query that runs the divide then steps the 16-step bit-serial
//   restoring divider before its result is loaded.
//   A finished result waits in the output register while the next event is
//   taken; if the receiver stalls, the following result waits in the
//   controller until the output register drains.
//   Register port: byte 0 is the missing-stamp back-off, byte 4 the
//   missing-stamp up credit, both 10 bits. Write only while idle.
//   Reset frees both slots, clears held, down, start stamp and accumulator,
//   and loads back-off 100 and credit 10.
// ----------------------------------------------------------------------------
module button_hold_time_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bhtt_pkg::ACT_W-1:0]     in_action,
  input  logic                           in_key_given,
  input  logic [bhtt_pkg::KEY_W-1:0]     in_key_code,
  input  logic [bhtt_pkg::STAMP_W-1:0]   in_event_stamp,
  input  logic [bhtt_pkg::STAMP_W-1:0]   in_now_ms,
  input  logic [bhtt_pkg::FRAME_W-1:0]   in_frame_msec,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bhtt_pkg::FRAC_W-1:0]    out_fraction,
  output logic                           out_held,
  output logic                           out_down_impulse,
  output logic                           out_third_key_refused,
  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bhtt_pkg::APB_AW-1:0]    paddr,
  input  logic [bhtt_pkg::APB_DW-1:0]    pwdata,
  output logic [bhtt_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import bhtt_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [CFG_W-1:0] backoff_r, backoff_nxt;
  logic [CFG_W-1:0] credit_r, credit_nxt;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  // Register port decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    backoff_nxt = backoff_r;
    credit_nxt  = credit_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BACKOFF: backoff_nxt = pwdata[CFG_W-1:0];
        REG_CREDIT:  credit_nxt  = pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BACKOFF: prdata = {{(APB_DW-CFG_W){1'b0}}, backoff_r};
      REG_CREDIT:  prdata = {{(APB_DW-CFG_W){1'b0}}, credit_r};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r <= BACKOFF_RST;
      credit_r  <= CREDIT_RST;
    end else begin
      backoff_r <= backoff_nxt;
      credit_r  <= credit_nxt;
    end
  end

  // Sequencer
  bhtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  bhtt_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .backoff               (backoff_r),
    .credit                (credit_r),
    .in_action             (in_action),
    .in_key_given          (in_key_given),
    .in_key_code           (in_key_code),
    .in_event_stamp        (in_event_stamp),
    .in_now_ms             (in_now_ms),
    .in_frame_msec         (in_frame_msec),
    .out_fraction          (out_fraction),
    .out_held              (out_held),
    .out_down_impulse      (out_down_impulse),
    .out_third_key_refused (out_third_key_refused)
  );

  // A refusal needs both slots busy, which implies the button is held
  a_refused_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_third_key_refused |-> out_held)
    else $error("refused third key reported while button not held");

  // Fraction never exceeds one
  a_fraction_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fraction <= ONE_Q16))
    else $error("fraction above one");

  // An accepted event blocks the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an event is in progress");

endmodule

// File: design/bhtt_ctrl.sv
// ----------------------------------------------------------------------------
// bhtt_ctrl
// Sequencer: takes one event, steps the datapath through update, accumulate,
// fraction divide and result load, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bhtt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bhtt_pkg::sts_t sts,
  output bhtt_pkg::cmd_t cmd
);
  import bhtt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result register can take a new value when empty or draining now
  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.is_query ? S_PREP : S_FIN;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until transferred
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/bhtt_dp.sv
// ----------------------------------------------------------------------------
// bhtt_dp
// Datapath: holder slots, held and down bits, start stamp, saturating hold
// accumulator, bit-serial fraction divider and the result register.
// ----------------------------------------------------------------------------
module bhtt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bhtt_pkg::cmd_t                   cmd,
  output bhtt_pkg::sts_t                   sts,
  input  logic [bhtt_pkg::CFG_W-1:0]       backoff,
  input  logic [bhtt_pkg::CFG_W-1:0]       credit,
  input  logic [bhtt_pkg::ACT_W-1:0]       in_action,
  input  logic                             in_key_given,
  input  logic [bhtt_pkg::KEY_W-1:0]       in_key_code,
  input  logic [bhtt_pkg::STAMP_W-1:0]     in_event_stamp,
  input  logic [bhtt_pkg::STAMP_W-1:0]     in_now_ms,
  input  logic [bhtt_pkg::FRAME_W-1:0]     in_frame_msec,
  output logic [bhtt_pkg::FRAC_W-1:0]      out_fraction,
  output logic                             out_held,
  output logic                             out_down_impulse,
  output logic                             out_third_key_refused
);
  import bhtt_pkg::*;

  // Captured event
  action_t              act_r;
  logic                 kgiven_r;
  logic [KEY_W-1:0]     kcode_r;
  logic [STAMP_W-1:0]   stamp_r;
  logic [STAMP_W-1:0]   now_r;
  logic [FRAME_W-1:0]   frame_r;

  // Button state
  logic [SLOT_W-1:0]    slot_r   [KEY_SLOTS];
  logic [SLOT_W-1:0]    slot_nxt [KEY_SLOTS];
  logic                 held_r, held_nxt;
  logic                 down_r, down_nxt;
  logic [STAMP_W-1:0]   start_r, start_nxt;
  logic [STAMP_W-1:0]   total_r, total_nxt;

  // Work registers
  logic [STAMP_W-1:0]   amt_r, amt_nxt;
  logic                 add_en_r, add_en_nxt;
  logic                 refused_r, refused_nxt;
  logic [FRAC_W-1:0]    frac_r, frac_nxt;
  logic [FRAME_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // Result register
  logic [FRAC_W-1:0]    o_frac_r;
  logic                 o_held_r, o_down_r, o_ref_r;

  // Event decode helpers
  logic [SLOT_W-1:0]    key;
  logic [SLOT_W-1:0]    upkey;
  logic [STAMP_W-1:0]   diff_src;
  logic [STAMP_W-1:0]   diff;
  logic                 later;
  logic                 seen;
  logic [STAMP_W:0]     sum;
  logic [STAMP_W-1:0]   frame_ext;
  logic [FRAME_W:0]     rem2;
  logic                 ge;

  assign key       = kgiven_r ? {1'b0, kcode_r} : NO_KEY_MARK;
  assign upkey     = {1'b0, kcode_r};
  assign diff_src  = (act_r == ACT_UP) ? stamp_r : now_r;
  assign diff      = diff_src - start_r;
  assign later     = diff_src > start_r;
  assign seen      = (slot_r[0] == key) || (slot_r[1] == key);
  assign sum       = {1'b0, total_r} + {1'b0, amt_r};
  assign frame_ext = {{(STAMP_W-FRAME_W){1'b0}}, frame_r};
  assign rem2      = {rem_r, 1'b0};
  assign ge        = rem2 >= {1'b0, frame_r};

  // Status to the sequencer
  assign sts.is_query = (act_r == ACT_QUERY);
  assign sts.need_div = (frame_r != '0) && (total_r < frame_ext);
  assign sts.div_last = (cnt_r == '0);

  // Next values of state and work registers
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    held_nxt    = held_r;
    down_nxt    = down_r;
    start_nxt   = start_r;
    total_nxt   = total_r;
    amt_nxt     = amt_r;
    add_en_nxt  = add_en_r;
    refused_nxt = refused_r;
    frac_nxt    = frac_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;

    // Apply the event to slots and bits, stage the amount to add
    if (cmd.exec) begin
      add_en_nxt  = 1'b0;
      amt_nxt     = '0;
      refused_nxt = 1'b0;
      frac_nxt    = '0;
      unique case (act_r)
        ACT_DOWN: begin
          if (!seen) begin
            priority if (slot_r[0] == SLOT_FREE) begin
              slot_nxt[0] = key;
            end else if (slot_r[1] == SLOT_FREE) begin
              slot_nxt[1] = key;
            end else begin
              refused_nxt = 1'b1;
            end
            if (!refused_nxt && !held_r) begin
              start_nxt = (stamp_r != '0) ? stamp_r
                        : now_r - {{(STAMP_W-CFG_W){1'b0}}, backoff};
              held_nxt  = 1'b1;
              down_nxt  = 1'b1;
            end
          end
        end
        ACT_UP: begin
          if (!kgiven_r) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
              slot_nxt[i] = SLOT_FREE;
            end
            held_nxt = 1'b0;
            down_nxt = 1'b0;
          end else begin
            if (slot_r[0] == upkey) begin
              slot_nxt[0] = SLOT_FREE;
            end else if (slot_r[1] == upkey) begin
              slot_nxt[1] = SLOT_FREE;
            end
            if (((slot_r[0] == upkey) || (slot_r[1] == upkey)) &&
                (slot_nxt[0] == SLOT_FREE) && (slot_nxt[1] == SLOT_FREE) &&
                held_r) begin
              if (stamp_r == '0) begin
                amt_nxt    = {{(STAMP_W-CFG_W){1'b0}}, credit};
                add_en_nxt = 1'b1;
              end else if (later) begin
                amt_nxt    = diff;
                add_en_nxt = 1'b1;
              end
              held_nxt = 1'b0;
            end
          end
        end
        ACT_CLEAR: begin
          total_nxt = '0;
          down_nxt  = 1'b0;
          if (held_r) begin
            start_nxt = now_r;
          end
        end
        ACT_QUERY: begin
          if (held_r) begin
            if (later) begin
              amt_nxt    = diff;
              add_en_nxt = 1'b1;
            end
            start_nxt = now_r;
          end
        end
        default: begin
        end
      endcase
    end

    // Saturating add into the hold accumulator
    if (cmd.acc && add_en_r) begin
      total_nxt = sum[STAMP_W] ? TOTAL_MAX : sum[STAMP_W-1:0];
    end

    // Set up the divide or settle the clamped cases
    if (cmd.prep) begin
      priority if (frame_r == '0) begin
        frac_nxt = held_r ? ONE_Q16 : '0;
      end else if (total_r >= frame_ext) begin
        frac_nxt = ONE_Q16;
      end else begin
        frac_nxt = '0;
      end
      rem_nxt = total_r[FRAME_W-1:0];
      cnt_nxt = CNT_W'(QBITS - 1);
    end

    // One restoring divide step per cycle
    if (cmd.div_step) begin
      rem_nxt  = ge ? FRAME_W'(rem2 - {1'b0, frame_r}) : rem2[FRAME_W-1:0];
      frac_nxt = {frac_r[FRAC_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  // Button state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slot_r[i] <= SLOT_FREE;
      end
      held_r  <= 1'b0;
      down_r  <= 1'b0;
      start_r <= '0;
      total_r <= '0;
    end else begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
      held_r  <= held_nxt;
      down_r  <= down_nxt;
      start_r <= start_nxt;
      total_r <= total_nxt;
    end
  end

  // Event capture, work and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r    <= action_t'(in_action);
      kgiven_r <= in_key_given;
      kcode_r  <= in_key_code;
      stamp_r  <= in_event_stamp;
      now_r    <= in_now_ms;
      frame_r  <= in_frame_msec;
    end
    amt_r     <= amt_nxt;
    add_en_r  <= add_en_nxt;
    refused_r <= refused_nxt;
    frac_r    <= frac_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    if (cmd.out_load) begin
      o_frac_r <= frac_r;
      o_held_r <= held_r;
      o_down_r <= down_r;
      o_ref_r  <= refused_r;
    end
  end

  assign out_fraction          = o_frac_r;
  assign out_held              = o_held_r;
  assign out_down_impulse      = o_down_r;
  assign out_third_key_refused = o_ref_r;

endmodule
